[src/indexed_min_heap_queue_assert.svh]
// Assertion macros for the indexed min-heap queue.
// Included by the top level only; needs no package.
`ifndef INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH

// Implication checked on every rising clock edge while out of reset.
`define IMHQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define IMHQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

[src/imhq_pkg.sv]
// Package for the indexed min-heap queue: payload structs, codes, states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned HandleW = 10;
  localparam int unsigned CountW  = 9;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NOP    = 2'd3
  } op_e_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [HandleW-1:0] out_handle;
    logic [KeyW-1:0]    out_key;
    logic [CountW-1:0]  count;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,    // position map read data is available
    S_POPRD,    // read root and last slot
    S_POPWR,    // move last entry to root (pop) or write the new key (update)
    S_UPRD,     // read current and parent slot
    S_UPCMP,    // compare and maybe swap with parent
    S_DNRD,     // read current and left child
    S_DNRD2,    // read right child
    S_DNSEL,    // pick the smaller child
    S_DNCMP,    // compare and maybe swap with best child
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[src/imhq_ctrl.sv]
// Sequencer for the indexed min-heap queue: one shared key comparator,
// heap and position memories. Depends on imhq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imhq_ctrl #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned HANDLE_COUNT = 1024,
  parameter int unsigned KEY_WIDTH    = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire imhq_pkg::in_item_t   item,
  output logic                      busy,
  output logic                      done,
  output imhq_pkg::out_item_t       result
);
  import imhq_pkg::*;

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = SW + 1;  // slot plus presence bit

  // Heap memories and position map.
  logic [KEY_WIDTH-1:0] hkey_mem [CAPACITY];
  logic [HW-1:0]        hhdl_mem [CAPACITY];
  logic [PW-1:0]        pos_mem  [HANDLE_COUNT];

  // Clearing pass over the position map after reset.
  logic [HW:0] clr_r, clr_nxt;
  wire clearing = (clr_r != (HW+1)'(HANDLE_COUNT));

  state_t state_r, state_nxt;
  logic [1:0]           op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [HandleW-1:0]   hin_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]        cur_r, oth_r;
  logic [KEY_WIDTH-1:0] ck_r, ok_r;
  logic [HW-1:0]        ch_r, oh_r;
  logic                 rv_r;
  logic                 uph_r;   // update also sinks after rising
  out_item_t            res_r;

  // Read ports (registered data), addressed combinationally.
  logic [SW-1:0] ra_a, ra_b;
  logic [KEY_WIDTH-1:0] rdk_a, rdk_b;
  logic [HW-1:0] rdh_a, rdh_b;
  logic [PW-1:0] pos_rd;
  logic [HW-1:0] pos_ra;

  // Write controls: up to two heap slots and two position entries per cycle.
  logic          we_a, we_b, pwe_a, pwe_b;
  logic [SW-1:0] wa_a, wa_b;
  logic [KEY_WIDTH-1:0] wk_a, wk_b;
  logic [HW-1:0] wh_a, wh_b, pa_a, pa_b;
  logic [PW-1:0] pd_a, pd_b;

  wire [KEY_WIDTH-1:0] key_in = item.key[KEY_WIDTH-1:0];
  wire in_range = ({22'd0, item.handle} < 32'(HANDLE_COUNT));
  wire [HW-1:0] h_in = item.handle[HW-1:0];

  // Child index helpers.
  wire [SW:0]  left_w  = {cur_r, 1'b1};
  wire [SW:0]  right_w = {cur_r, 1'b0} + (SW+1)'(2);
  wire [SW-1:0] par_w  = SW'((cur_r - SW'(1)) >> 1);

  // Shared comparator.
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  wire cmp_lt = cmp_a < cmp_b;

  always_ff @(posedge clk) begin
    rdk_a  <= hkey_mem[ra_a];
    rdh_a  <= hhdl_mem[ra_a];
    rdk_b  <= hkey_mem[ra_b];
    rdh_b  <= hhdl_mem[ra_b];
    pos_rd <= pos_mem[pos_ra];
    if (we_a) begin
      hkey_mem[wa_a] <= wk_a;
      hhdl_mem[wa_a] <= wh_a;
    end
    if (we_b) begin
      hkey_mem[wa_b] <= wk_b;
      hhdl_mem[wa_b] <= wh_b;
    end
    if (pwe_a) pos_mem[pa_a] <= pd_a;
    if (pwe_b) pos_mem[pa_b] <= pd_b;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_PUSH:
            if (cnt_r < CW'(CAPACITY) && rv_r && !pos_rd[PW-1]) state_nxt = S_UPRD;
          OP_POP:    if (cnt_r != '0) state_nxt = S_POPRD;
          OP_UPDATE: if (rv_r && pos_rd[PW-1]) state_nxt = S_POPWR;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_POPRD: state_nxt = S_POPWR;
      S_POPWR: state_nxt = (op_r == OP_UPDATE) ? S_UPRD : S_DNRD;
      S_UPRD:  state_nxt = (cur_r == '0) ? (uph_r ? S_DNRD : S_DONE) : S_UPCMP;
      S_UPCMP: state_nxt = cmp_lt ? S_UPRD : (uph_r ? S_DNRD : S_DONE);
      S_DNRD:  state_nxt = (left_w >= (SW+1)'(cnt_r)) ? S_DONE : S_DNRD2;
      S_DNRD2: state_nxt = S_DNSEL;
      S_DNSEL: state_nxt = S_DNCMP;
      S_DNCMP: state_nxt = cmp_lt ? S_DNRD : S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls per state.
  always_comb begin
    ra_a = cur_r; ra_b = oth_r;
    pos_ra = clearing ? clr_r[HW-1:0] : ((state_r == S_IDLE) ? h_in : hin_r[HW-1:0]);
    we_a = 1'b0; we_b = 1'b0; pwe_a = 1'b0; pwe_b = 1'b0;
    wa_a = cur_r; wa_b = oth_r; wk_a = ck_r; wk_b = ok_r; wh_a = ch_r; wh_b = oh_r;
    pa_a = ch_r; pa_b = oh_r; pd_a = {1'b1, cur_r}; pd_b = {1'b1, oth_r};
    cmp_a = ck_r; cmp_b = ok_r;
    case (state_r)
      S_CHECK: begin
        if (op_r == OP_PUSH && cnt_r < CW'(CAPACITY) && rv_r && !pos_rd[PW-1]) begin
          we_a = 1'b1; wa_a = cnt_r[SW-1:0]; wk_a = key_r; wh_a = hin_r[HW-1:0];
          pwe_a = 1'b1; pa_a = hin_r[HW-1:0]; pd_a = {1'b1, cnt_r[SW-1:0]};
        end
        ra_a = '0; ra_b = SW'(cnt_r - CW'(1));
      end
      S_POPRD: begin
        ra_a = '0; ra_b = SW'(cnt_r - CW'(1));
      end
      S_POPWR: begin
        if (op_r == OP_POP) begin
          pwe_a = 1'b1; pa_a = rdh_a; pd_a = '0;
          if (cnt_r != CW'(1)) begin
            we_a = 1'b1; wa_a = '0; wk_a = rdk_b; wh_a = rdh_b;
            pwe_b = 1'b1; pa_b = rdh_b; pd_b = {1'b1, SW'(0)};
          end
        end else begin
          we_a = 1'b1; wa_a = pos_rd[SW-1:0]; wk_a = key_r; wh_a = hin_r[HW-1:0];
        end
      end
      S_UPRD: begin
        ra_a = cur_r; ra_b = par_w;
      end
      S_UPCMP: begin
        cmp_a = rdk_a; cmp_b = rdk_b;
        if (cmp_lt) begin
          we_a = 1'b1; wa_a = cur_r; wk_a = rdk_b; wh_a = rdh_b;
          we_b = 1'b1; wa_b = par_w; wk_b = rdk_a; wh_b = rdh_a;
          pwe_a = 1'b1; pa_a = rdh_b; pd_a = {1'b1, cur_r};
          pwe_b = 1'b1; pa_b = rdh_a; pd_b = {1'b1, par_w};
        end
      end
      S_DNRD: begin
        ra_a = cur_r; ra_b = left_w[SW-1:0];
      end
      S_DNRD2: begin
        ra_a = right_w[SW-1:0]; ra_b = left_w[SW-1:0];
      end
      // Right child against left child; a tie keeps the left one.
      S_DNSEL: begin
        cmp_a = rdk_a; cmp_b = ok_r;
      end
      // Smaller child against the sinking entry.
      S_DNCMP: begin
        cmp_a = ok_r; cmp_b = ck_r;
        if (cmp_lt) begin
          we_a = 1'b1; wa_a = cur_r; wk_a = ok_r; wh_a = oh_r;
          we_b = 1'b1; wa_b = oth_r; wk_b = ck_r; wh_b = ch_r;
          pwe_a = 1'b1; pa_a = oh_r; pd_a = {1'b1, cur_r};
          pwe_b = 1'b1; pa_b = ch_r; pd_b = {1'b1, oth_r};
        end
      end
      default: ;
    endcase
    if (clearing) begin
      pwe_a = 1'b1; pa_a = clr_r[HW-1:0]; pd_a = '0; pwe_b = 1'b0;
    end
  end

  // Position clearing counter.
  always_comb begin
    clr_nxt = clearing ? clr_r + (HW+1)'(1) : clr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Count update.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == S_CHECK && op_r == OP_PUSH && cnt_r < CW'(CAPACITY) && rv_r &&
        !pos_rd[PW-1])
      cnt_nxt = cnt_r + CW'(1);
    if (state_r == S_POPWR && op_r == OP_POP) cnt_nxt = cnt_r - CW'(1);
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        op_r <= item.op; key_r <= key_in; hin_r <= item.handle; rv_r <= in_range;
        res_r <= '{status: ST_OK, out_handle: item.handle, out_key: '0, count: '0};
      end
      S_CHECK: begin
        uph_r <= (op_r != OP_PUSH);
        cur_r <= cnt_r[SW-1:0];
        if (op_r == OP_PUSH) begin
          if (cnt_r >= CW'(CAPACITY)) res_r.status <= ST_FULL;
          else if (!rv_r) res_r.status <= ST_ABSENT;
          else if (pos_rd[PW-1]) res_r.status <= ST_PRESENT;
        end else if (op_r == OP_POP) begin
          if (cnt_r == '0) res_r.status <= ST_EMPTY;
        end else if (op_r == OP_UPDATE) begin
          if (!(rv_r && pos_rd[PW-1])) res_r.status <= ST_ABSENT;
        end
      end
      S_POPWR: begin
        if (op_r == OP_POP) begin
          res_r.out_handle <= HandleW'(rdh_a);
          res_r.out_key <= 32'(rdk_a);
          cur_r <= '0;
        end else begin
          cur_r <= pos_rd[SW-1:0];
        end
      end
      S_UPRD: oth_r <= par_w;
      S_UPCMP: if (cmp_lt) cur_r <= par_w;
      S_DNRD2: begin
        ck_r <= rdk_a; ch_r <= rdh_a; ok_r <= rdk_b; oh_r <= rdh_b;
      end
      S_DNSEL: begin
        if (right_w < (SW+1)'(cnt_r) && cmp_lt) begin
          ok_r <= rdk_a; oh_r <= rdh_a; oth_r <= right_w[SW-1:0];
        end else begin
          oth_r <= left_w[SW-1:0];
        end
      end
      S_DNCMP: if (cmp_lt) cur_r <= oth_r;
      default: ;
    endcase
  end

  // DNRD presents current and left, DNRD2 captures them and presents the
  // right child, which DNSEL sees on port a.
  assign busy   = (state_r != S_IDLE) || clearing;
  assign done   = (state_r == S_DONE);
  always_comb begin
    result = res_r;
    result.count = CountW'(cnt_r);
  end

endmodule
`default_nettype wire

[src/indexed_min_heap_queue.sv]
// Top level of the indexed min-heap queue: handshakes and output register.
// Depends on imhq_pkg, imhq_ctrl and indexed_min_heap_queue_assert.svh.
//
// Channel   Direction  Handshake        Payload
// in_       input      valid / stall    imhq_pkg::in_item_t
// out_      output     valid / stall    imhq_pkg::out_item_t
//
// A push climbs toward the root; a pop moves the last entry to the root and
// descends; an update climbs and then descends. The result is registered in
// the output register; the single heap memory and the shared comparator walk
// one level at a time. After reset the position map is cleared, one handle
// per cycle, while in_stall is high.
// A result waits in the output register; no new item is taken while it is
// stalled there.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_queue_assert.svh"
module indexed_min_heap_queue #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned HANDLE_COUNT = 1024,
  parameter int unsigned KEY_WIDTH    = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire imhq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output imhq_pkg::out_item_t      out_data
);
  import imhq_pkg::*;

  logic busy, done;
  logic held_r, held_nxt;
  out_item_t res, hold_r;
  logic ov_r, ov_nxt;

  imhq_ctrl #(.CAPACITY(CAPACITY), .HANDLE_COUNT(HANDLE_COUNT), .KEY_WIDTH(KEY_WIDTH))
    u_ctrl (.clk(clk), .rst_n(rst_n), .start(in_valid && !in_stall), .item(in_data),
            .busy(busy), .done(done), .result(res));

  // Accept only when the engine is free and no result is stalled in the output register.
  assign in_stall = busy || (ov_r && out_stall && held_r);

  // Output register holds one result until transfer.
  always_comb begin
    ov_nxt = ov_r;
    held_nxt = held_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (done) ov_nxt = 1'b1;
    held_nxt = ov_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      held_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) hold_r <= res;
  end

  assign out_valid = ov_r;
  assign out_data  = hold_r;

  `IMHQ_ASSERT_IMP(a_no_accept_busy, clk, rst_n, busy, in_stall)
  `IMHQ_ASSERT_NXT(a_done_valid, clk, rst_n, done, out_valid)
  `IMHQ_ASSERT_IMP(a_done_free, clk, rst_n, done, !(ov_r && out_stall))

endmodule
`default_nettype wire

[bench/tb_indexed_min_heap_queue.sv]
// Self-checking bench for the indexed min-heap queue: directed table, fill to capacity, then random traffic.
// Depends on imhq_pkg and the indexed_min_heap_queue top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_indexed_min_heap_queue;
  import imhq_pkg::*;

  localparam int unsigned Cap     = 256;
  localparam int unsigned Handles = 1024;
  localparam int          Limit   = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  indexed_min_heap_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predicted heap contents.
  logic [KeyW-1:0]    pq_keys [Cap];
  logic [HandleW-1:0] pq_handles [Cap];
  int unsigned        pq_slot [Handles];
  bit                 pq_present [Handles];
  int unsigned        pq_count;

  out_item_t expected_results[$];
  bit        failed;
  int        idle_cycles;

  // Directed rows: item plus an optional fixed expectation.
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t result;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KeyW-1:0]    k;
    logic [HandleW-1:0] h;
    k = pq_keys[a]; h = pq_handles[a];
    pq_keys[a] = pq_keys[b]; pq_handles[a] = pq_handles[b];
    pq_keys[b] = k; pq_handles[b] = h;
    pq_slot[pq_handles[a]] = a;
    pq_slot[pq_handles[b]] = b;
  endfunction

  function automatic int unsigned climb(int unsigned i);
    int unsigned p;
    while (i != 0 && i < pq_count) begin
      p = (i - 1) / 2;
      if (!(pq_keys[i] < pq_keys[p])) break;
      swap_slots(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void descend(int unsigned i);
    int unsigned l;
    int unsigned best;
    while (i < pq_count) begin
      l = 2 * i + 1;
      if (l >= pq_count) break;
      best = l;
      if (l + 1 < pq_count && pq_keys[l + 1] < pq_keys[l]) best = l + 1;
      if (!(pq_keys[best] < pq_keys[i])) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  // Apply one operation to the predicted heap and return its result.
  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t   r;
    int unsigned s;
    r.status = ST_OK;
    r.out_handle = it.handle;
    r.out_key = '0;
    case (it.op)
      OP_PUSH: begin
        if (pq_count >= Cap) r.status = ST_FULL;
        else if (pq_present[it.handle]) r.status = ST_PRESENT;
        else begin
          s = pq_count;
          pq_keys[s] = it.key;
          pq_handles[s] = it.handle;
          pq_slot[it.handle] = s;
          pq_present[it.handle] = 1'b1;
          pq_count = s + 1;
          void'(climb(s));
        end
      end
      OP_POP: begin
        if (pq_count == 0) r.status = ST_EMPTY;
        else begin
          r.out_handle = pq_handles[0];
          r.out_key = pq_keys[0];
          pq_present[pq_handles[0]] = 1'b0;
          if (pq_count > 1) begin
            pq_keys[0] = pq_keys[pq_count - 1];
            pq_handles[0] = pq_handles[pq_count - 1];
            pq_slot[pq_handles[0]] = 0;
          end
          pq_count = pq_count - 1;
          descend(0);
        end
      end
      OP_UPDATE: begin
        if (!pq_present[it.handle]) r.status = ST_ABSENT;
        else begin
          s = pq_slot[it.handle];
          pq_keys[s] = it.key;
          descend(climb(s));
        end
      end
      default: ;
    endcase
    r.count = pq_count[CountW-1:0];
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [KeyW-1:0] key,
                                         logic [HandleW-1:0] h);
    in_item_t it;
    it.op = op; it.key = key; it.handle = h;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit fixed, logic [2:0] st,
                                  logic [HandleW-1:0] oh, logic [KeyW-1:0] ok,
                                  int unsigned cnt);
    row_t rw;
    rw.item = it;
    rw.fixed = fixed;
    rw.result.status = st;
    rw.result.out_handle = oh;
    rw.result.out_key = ok;
    rw.result.count = cnt[CountW-1:0];
    rows = {rows, rw};
  endfunction

  // Random handle: mostly present ones so updates and duplicate pushes land.
  function automatic logic [HandleW-1:0] pick_handle();
    int unsigned h;
    if ($urandom_range(0, 2) != 0) begin
      for (int t = 0; t < 8; t++) begin
        h = $urandom_range(0, Handles - 1);
        if (pq_present[h]) return h[HandleW-1:0];
      end
    end
    return HandleW'($urandom_range(0, Handles - 1));
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Present one item and record its expectation on transfer.
  task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_res);
    out_item_t   pred;
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = heap_apply(it);
    if (fixed && pred != fixed_res) begin
      $error("table row disagrees with predictor: %h vs %h", fixed_res, pred);
      failed = 1'b1;
    end
    expected_results = {expected_results, (fixed ? fixed_res : pred)};
  endtask

  // Result side: a random wait before each transfer, field-by-field compare.
  initial begin
    out_item_t   want;
    int unsigned gap;
    out_stall = 1'b1;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_data.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failed = 1'b1;
        end
        if (out_data.out_handle != want.out_handle) begin
          $error("out_handle: expected %0d, got %0d", want.out_handle, out_data.out_handle);
          failed = 1'b1;
        end
        if (out_data.out_key != want.out_key) begin
          $error("out_key: expected %h, got %h", want.out_key, out_data.out_key);
          failed = 1'b1;
        end
        if (out_data.count != want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; the clearing pass fits inside.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= Limit) begin
        $display("** indexed_min_heap_queue: FAILED **");
        $finish;
      end
    end
  end

  // Main stimulus.
  initial begin
    out_item_t dummy;
    in_item_t  it;
    int        burst;
    failed = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    dummy = '0;
    pq_count = 0;
    foreach (pq_present[i]) pq_present[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty pop, extremes, duplicates, ties, updates, unused op.
    add_row(make_item(OP_POP, 32'h1234, 10'd7), 1, ST_EMPTY, 10'd7, '0, 0);
    add_row(make_item(OP_UPDATE, 32'd5, 10'd3), 1, ST_ABSENT, 10'd3, '0, 0);
    add_row(make_item(OP_PUSH, 32'hFFFF_FFFF, 10'd1023), 1, ST_OK, 10'd1023, '0, 1);
    add_row(make_item(OP_PUSH, 32'd0, 10'd0), 1, ST_OK, 10'd0, '0, 2);
    add_row(make_item(OP_PUSH, 32'd9, 10'd0), 1, ST_PRESENT, 10'd0, '0, 2);
    add_row(make_item(OP_PUSH, 32'd0, 10'd5), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_PUSH, 32'd100, 10'd6), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_PUSH, 32'd50, 10'd8), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_NOP, 32'hA5A5_A5A5, 10'd512), 1, ST_OK, 10'd512, '0, 5);
    add_row(make_item(OP_UPDATE, 32'd1, 10'd1023), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_UPDATE, 32'hFFFF_FFFF, 10'd0), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_UPDATE, 32'd50, 10'd6), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_POP, '0, '0), 1, ST_OK, 10'd5, 32'd0, 4);
    add_row(make_item(OP_POP, '0, '0), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_POP, '0, '0), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_POP, '0, '0), 0, ST_OK, '0, '0, 0);
    add_row(make_item(OP_POP, '0, '0), 1, ST_OK, 10'd0, 32'hFFFF_FFFF, 0);
    add_row(make_item(OP_POP, '0, 10'd1023), 1, ST_EMPTY, 10'd1023, '0, 0);
    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].result);

    // Fill to capacity once, hit the full case, then drain.
    for (int i = 0; i < Cap; i++)
      send_item(make_item(OP_PUSH, pick_key(), i[HandleW-1:0] + 10'd700), 0, dummy);
    send_item(make_item(OP_PUSH, 32'd3, 10'd1), 1, '{ST_FULL, 10'd1, '0, 9'd256});
    send_item(make_item(OP_UPDATE, 32'd0, 10'd800), 0, dummy);
    for (int i = 0; i < Cap; i++) send_item(make_item(OP_POP, '0, '0), 0, dummy);

    // Random phases: push-heavy, mixed, pop-heavy bursts.
    for (int n = 0; n < 800; n++) begin
      burst = (n / 100) % 3;
      case ($urandom_range(0, 9))
        0, 1, 2: it = make_item(burst == 2 ? OP_POP : OP_PUSH, pick_key(), pick_handle());
        3, 4:    it = make_item(burst == 0 ? OP_PUSH : OP_POP, pick_key(), pick_handle());
        5, 6, 7: it = make_item(OP_UPDATE, pick_key(), pick_handle());
        8:       it = make_item(OP_POP, $urandom, HandleW'($urandom));
        default: it = make_item(2'($urandom_range(0, 3)), $urandom, HandleW'($urandom));
      endcase
      send_item(it, 0, dummy);
    end
    in_valid <= 1'b0;

    // Drain the expectation queue, then a tail for the last result.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("** indexed_min_heap_queue: PASSED **");
    end else begin
      $display("** indexed_min_heap_queue: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
